/* design/c_subset_lexer_macros.svh */
// Assertion macros for the c_subset_lexer block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef C_SUBSET_LEXER_MACROS_SVH
`define C_SUBSET_LEXER_MACROS_SVH

// same-cycle implication
`define CSLX_CHK_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CSLX_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/cslx_pkg.sv */
// Package for the c_subset_lexer block: token codes, lexer modes, item types
// and character classification functions. No dependencies.
package cslx_pkg;

  localparam int MAX_TOKEN_LEN = 255;
  localparam int QUEUE_DEPTH   = 4;
  localparam int PREFIX_CHARS  = 6;
  localparam int KW_COUNT      = 10;

  typedef enum logic [3:0] {
    M_IDLE  = 4'd0,
    M_PIPE  = 4'd1,
    M_AMP   = 4'd2,
    M_LT    = 4'd3,
    M_GT    = 4'd4,
    M_EQ    = 4'd5,
    M_PLUS  = 4'd6,
    M_MINUS = 4'd7,
    M_STAR  = 4'd8,
    M_SLASH = 4'd9,
    M_NUM   = 4'd10,
    M_WORD  = 4'd11
  } lexer_mode_t;

  // characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_PIPE  = 8'h7c;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_SLASH = 8'h2f;

  // token codes
  localparam logic signed [9:0] T_EQ     = 10'sd256;
  localparam logic signed [9:0] T_LE     = 10'sd258;
  localparam logic signed [9:0] T_INC    = 10'sd259;
  localparam logic signed [9:0] T_DEC    = 10'sd260;
  localparam logic signed [9:0] T_AND    = 10'sd261;
  localparam logic signed [9:0] T_GE     = 10'sd262;
  localparam logic signed [9:0] T_OR     = 10'sd263;
  localparam logic signed [9:0] T_FOR    = 10'sd264;
  localparam logic signed [9:0] T_SWITCH = 10'sd265;
  localparam logic signed [9:0] T_CASE   = 10'sd266;
  localparam logic signed [9:0] T_IF     = 10'sd267;
  localparam logic signed [9:0] T_ELSE   = 10'sd268;
  localparam logic signed [9:0] T_WHILE  = 10'sd269;
  localparam logic signed [9:0] T_TYPE   = 10'sd270;
  localparam logic signed [9:0] T_ID     = 10'sd271;
  localparam logic signed [9:0] T_INT    = 10'sd272;
  localparam logic signed [9:0] T_END    = -10'sd1;
  localparam logic signed [9:0] T_BAD    = -10'sd100;

  localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
    48'h0000_0066_6f72,  // for
    48'h7377_6974_6368,  // switch
    48'h0000_6361_7365,  // case
    48'h0000_0000_6966,  // if
    48'h0000_656c_7365,  // else
    48'h0077_6869_6c65,  // while
    48'h0000_0069_6e74,  // int
    48'h646f_7562_6c65,  // double
    48'h0066_6c6f_6174,  // float
    48'h0000_6368_6172   // char
  };

  localparam logic signed [9:0] KW_CODE [KW_COUNT] = '{
    T_FOR, T_SWITCH, T_CASE, T_IF, T_ELSE, T_WHILE, T_TYPE, T_TYPE, T_TYPE, T_TYPE
  };

  typedef struct packed {
    logic signed [9:0] code;
    logic [7:0]        len;
    logic              last;
  } token_t;

  // results of one input item
  typedef struct packed {
    logic   two;
    token_t t0;
    token_t t1;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    lexer_mode_t mode;
  } f_stat_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7a)) ||
           ((c >= 8'h41) && (c <= 8'h5a)) || (c == 8'h5f);
  endfunction

  // ( ) { } ; # [ ] : " ' !
  function automatic logic is_punct(input logic [7:0] c);
    return c inside {8'h28, 8'h29, 8'h7b, 8'h7d, 8'h3b, 8'h23,
                     8'h5b, 8'h5d, 8'h3a, 8'h22, 8'h27, 8'h21};
  endfunction

  function automatic logic signed [9:0] kw_code(input logic [47:0] pfx,
                                                input logic too_long);
    logic signed [9:0] code;
    code = T_ID;
    for (int i = 0; i < KW_COUNT; i++) begin
      if (pfx == KW_TEXT[i]) code = KW_CODE[i];
    end
    return too_long ? T_ID : code;
  endfunction

endpackage

/* design/cslx_front.sv */
// Front end of the c_subset_lexer: lexer state and classification of each
// character into zero, one or two tokens. Depends on cslx_pkg.
module cslx_front #(
  parameter int MAX_TOKEN_LEN = cslx_pkg::MAX_TOKEN_LEN
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc,
  input  logic [7:0]       ch,
  input  logic             eoi,
  output logic             q_push,
  output cslx_pkg::entry_t q_wr,
  output cslx_pkg::f_stat_t f_stat
);

  localparam int         LenCap = (MAX_TOKEN_LEN < 255) ? MAX_TOKEN_LEN : 255;
  localparam logic [7:0] CapW   = LenCap[7:0];
  localparam logic [7:0] PfxW   = 8'(cslx_pkg::PREFIX_CHARS);

  cslx_pkg::lexer_mode_t mode_r, mode_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [47:0] pfx_r, pfx_nxt;
  logic        long_r, long_nxt;

  // pending token, start-of-token and extension results
  cslx_pkg::token_t      pend_tok;
  logic                  st_emit;
  logic signed [9:0]     st_code;
  cslx_pkg::lexer_mode_t st_mode;
  logic                  ext_ok;
  logic                  ext_emit;
  logic signed [9:0]     ext_code;
  logic [7:0]            cnt_inc;
  logic                  do_start;

  always_comb begin
    pend_tok = '{code: cslx_pkg::T_END, len: 8'd0, last: 1'b0};
    case (mode_r)
      cslx_pkg::M_PIPE:  pend_tok = '{{2'b00, cslx_pkg::CH_PIPE},  8'd1, 1'b0};
      cslx_pkg::M_AMP:   pend_tok = '{{2'b00, cslx_pkg::CH_AMP},   8'd1, 1'b0};
      cslx_pkg::M_LT:    pend_tok = '{{2'b00, cslx_pkg::CH_LT},    8'd1, 1'b0};
      cslx_pkg::M_GT:    pend_tok = '{{2'b00, cslx_pkg::CH_GT},    8'd1, 1'b0};
      cslx_pkg::M_EQ:    pend_tok = '{{2'b00, cslx_pkg::CH_EQ},    8'd1, 1'b0};
      cslx_pkg::M_PLUS:  pend_tok = '{{2'b00, cslx_pkg::CH_PLUS},  8'd1, 1'b0};
      cslx_pkg::M_MINUS: pend_tok = '{{2'b00, cslx_pkg::CH_MINUS}, 8'd1, 1'b0};
      cslx_pkg::M_STAR:  pend_tok = '{{2'b00, cslx_pkg::CH_STAR},  8'd1, 1'b0};
      cslx_pkg::M_SLASH: pend_tok = '{{2'b00, cslx_pkg::CH_SLASH}, 8'd1, 1'b0};
      cslx_pkg::M_NUM:   pend_tok = '{cslx_pkg::T_INT, cnt_r, 1'b0};
      cslx_pkg::M_WORD:  pend_tok = '{cslx_pkg::kw_code(pfx_r, long_r), cnt_r, 1'b0};
      default:           pend_tok = '{cslx_pkg::T_END, 8'd0, 1'b0};
    endcase

    st_emit = 1'b0;
    st_code = cslx_pkg::T_BAD;
    st_mode = cslx_pkg::M_IDLE;
    case (ch)
      cslx_pkg::CH_SPACE, cslx_pkg::CH_NL: st_mode = cslx_pkg::M_IDLE;
      cslx_pkg::CH_PIPE:  st_mode = cslx_pkg::M_PIPE;
      cslx_pkg::CH_AMP:   st_mode = cslx_pkg::M_AMP;
      cslx_pkg::CH_LT:    st_mode = cslx_pkg::M_LT;
      cslx_pkg::CH_GT:    st_mode = cslx_pkg::M_GT;
      cslx_pkg::CH_EQ:    st_mode = cslx_pkg::M_EQ;
      cslx_pkg::CH_PLUS:  st_mode = cslx_pkg::M_PLUS;
      cslx_pkg::CH_MINUS: st_mode = cslx_pkg::M_MINUS;
      cslx_pkg::CH_STAR:  st_mode = cslx_pkg::M_STAR;
      cslx_pkg::CH_SLASH: st_mode = cslx_pkg::M_SLASH;
      default: begin
        if (cslx_pkg::is_punct(ch)) begin
          st_emit = 1'b1;
          st_code = {2'b00, ch};
        end else if (cslx_pkg::is_digit(ch)) begin
          st_mode = cslx_pkg::M_NUM;
        end else if (cslx_pkg::is_word(ch)) begin
          st_mode = cslx_pkg::M_WORD;
        end else begin
          st_emit = 1'b1;
          st_code = cslx_pkg::T_BAD;
        end
      end
    endcase

    ext_ok   = 1'b0;
    ext_emit = 1'b0;
    ext_code = cslx_pkg::T_EQ;
    case (mode_r)
      cslx_pkg::M_PIPE: begin
        ext_emit = (ch == cslx_pkg::CH_PIPE);
        ext_code = cslx_pkg::T_OR;
      end
      cslx_pkg::M_AMP: begin
        ext_emit = (ch == cslx_pkg::CH_AMP);
        ext_code = cslx_pkg::T_AND;
      end
      cslx_pkg::M_LT: begin
        ext_emit = (ch == cslx_pkg::CH_EQ);
        ext_code = cslx_pkg::T_LE;
      end
      cslx_pkg::M_GT: begin
        ext_emit = (ch == cslx_pkg::CH_EQ);
        ext_code = cslx_pkg::T_GE;
      end
      cslx_pkg::M_EQ: begin
        ext_emit = (ch == cslx_pkg::CH_EQ);
        ext_code = cslx_pkg::T_EQ;
      end
      cslx_pkg::M_PLUS: begin
        ext_emit = (ch == cslx_pkg::CH_EQ) || (ch == cslx_pkg::CH_PLUS);
        ext_code = (ch == cslx_pkg::CH_PLUS) ? cslx_pkg::T_INC : {2'b00, cslx_pkg::CH_EQ};
      end
      cslx_pkg::M_MINUS: begin
        ext_emit = (ch == cslx_pkg::CH_EQ) || (ch == cslx_pkg::CH_MINUS);
        ext_code = (ch == cslx_pkg::CH_MINUS) ? cslx_pkg::T_DEC : {2'b00, cslx_pkg::CH_EQ};
        ext_ok   = cslx_pkg::is_digit(ch);
      end
      cslx_pkg::M_STAR, cslx_pkg::M_SLASH: begin
        ext_emit = (ch == cslx_pkg::CH_EQ);
        ext_code = {2'b00, cslx_pkg::CH_EQ};
      end
      cslx_pkg::M_NUM:  ext_ok = cslx_pkg::is_digit(ch);
      cslx_pkg::M_WORD: ext_ok = cslx_pkg::is_word(ch);
      default: begin
        ext_emit = 1'b0;
        ext_ok   = 1'b0;
      end
    endcase
    ext_ok = ext_ok || ext_emit;

    cnt_inc  = (cnt_r < CapW) ? cnt_r + 8'd1 : cnt_r;
    do_start = !eoi && ((mode_r == cslx_pkg::M_IDLE) || !ext_ok);
  end

  // next state
  always_comb begin
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    pfx_nxt  = pfx_r;
    long_nxt = long_r;
    if (acc) begin
      if (eoi) begin
        mode_nxt = cslx_pkg::M_IDLE;
      end else if (do_start) begin
        mode_nxt = st_mode;
        if (st_mode == cslx_pkg::M_NUM) cnt_nxt = 8'd1;
        if (st_mode == cslx_pkg::M_WORD) begin
          cnt_nxt  = 8'd1;
          pfx_nxt  = {40'd0, ch};
          long_nxt = 1'b0;
        end
      end else if (ext_emit) begin
        mode_nxt = cslx_pkg::M_IDLE;
      end else if (mode_r == cslx_pkg::M_MINUS) begin
        mode_nxt = cslx_pkg::M_NUM;
        cnt_nxt  = 8'd2;
      end else if (mode_r == cslx_pkg::M_NUM) begin
        cnt_nxt = cnt_inc;
      end else begin
        if (cnt_r < PfxW) pfx_nxt = {pfx_r[39:0], ch};
        else long_nxt = 1'b1;
        cnt_nxt = cnt_inc;
      end
    end
  end

  // outputs
  always_comb begin
    logic             first_v;
    logic             second_v;
    cslx_pkg::token_t first;
    cslx_pkg::token_t second;
    first_v  = 1'b0;
    second_v = 1'b0;
    first    = pend_tok;
    second   = '{cslx_pkg::T_END, 8'd0, 1'b0};
    if (eoi) begin
      if (mode_r != cslx_pkg::M_IDLE) begin
        first_v  = 1'b1;
        second_v = 1'b1;
      end else begin
        first_v = 1'b1;
        first   = '{cslx_pkg::T_END, 8'd0, 1'b0};
      end
    end else if (mode_r == cslx_pkg::M_IDLE) begin
      first_v = st_emit;
      first   = '{st_code, 8'd1, 1'b0};
    end else if (ext_ok) begin
      first_v = ext_emit;
      first   = '{ext_code, 8'd2, 1'b0};
    end else begin
      first_v  = 1'b1;
      second_v = st_emit;
      second   = '{st_code, 8'd1, 1'b0};
    end
    first.last  = !second_v;
    second.last = 1'b1;
    q_push = acc && first_v;
    q_wr   = '{two: second_v, t0: first, t1: second};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= cslx_pkg::M_IDLE;
      cnt_r  <= '0;
      pfx_r  <= '0;
      long_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      pfx_r  <= pfx_nxt;
      long_r <= long_nxt;
    end
  end

  assign f_stat = '{mode: mode_r};

endmodule

/* design/cslx_queue.sv */
// Short queue of per-item token groups between front and back of the
// c_subset_lexer. Depends on cslx_pkg.
module cslx_queue #(
  parameter int QUEUE_DEPTH = cslx_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  cslx_pkg::entry_t   wr,
  input  logic               pop,
  output cslx_pkg::entry_t   rd,
  output cslx_pkg::q_stat_t  stat
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] DepthC  = CntW'(QUEUE_DEPTH);

  cslx_pkg::entry_t mem [QUEUE_DEPTH];
  cslx_pkg::entry_t rd_r;
  logic [PtrW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  always_comb begin
    do_push = push && (cnt_r != DepthC);
    do_pop  = pop && (cnt_r != '0);
    wp_nxt  = do_push ? ((wp_r == LastPtr) ? '0 : wp_r + 1'b1) : wp_r;
    rp_nxt  = do_pop ? ((rp_r == LastPtr) ? '0 : rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r + CntW'(do_push) - CntW'(do_pop);
  end

  // head entry is registered; a write into the next head slot passes through
  always_ff @(posedge clk) begin
    if (do_push) mem[wp_r] <= wr;
    rd_r <= (do_push && (wp_r == rp_nxt)) ? wr : mem[rp_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign rd   = rd_r;
  assign stat = '{full: (cnt_r == DepthC), empty: (cnt_r == '0)};

endmodule

/* design/cslx_back.sv */
// Back end of the c_subset_lexer: output register that hands out the tokens
// of each queued group one at a time. Depends on cslx_pkg.
module cslx_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cslx_pkg::entry_t         q_rd,
  input  cslx_pkg::q_stat_t        q_stat,
  output logic                     q_pop,
  output logic                     out_empty,
  input  logic                     out_pop,
  output logic signed [9:0]        out_token_code,
  output logic [7:0]               out_token_length,
  output logic                     out_last_of_run
);

  cslx_pkg::entry_t cur_r, cur_nxt;
  logic             vld_r, vld_nxt;
  logic             idx_r, idx_nxt;
  cslx_pkg::token_t tok;
  logic             take, done;

  always_comb begin
    take    = vld_r && out_pop;
    done    = take && (idx_r || !cur_r.two);
    q_pop   = !q_stat.empty && (!vld_r || done);
    cur_nxt = q_pop ? q_rd : cur_r;
    vld_nxt = q_pop ? 1'b1 : (done ? 1'b0 : vld_r);
    idx_nxt = q_pop ? 1'b0 : ((take && !done) ? 1'b1 : idx_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  assign tok              = idx_r ? cur_r.t1 : cur_r.t0;
  assign out_empty        = !vld_r;
  assign out_token_code   = tok.code;
  assign out_token_length = tok.len;
  assign out_last_of_run  = tok.last;

endmodule

/* design/c_subset_lexer.sv */
// Top level of the c_subset_lexer: front classifier, group queue, back end.
// Depends on cslx_pkg, cslx_front, cslx_queue, cslx_back and the macro header.
//
//   port group  | dir | handshake       | items
//   in_*        | in  | push / full     | ch, end_of_input
//   out_*       | out | empty / pop     | token_code, token_length, last_of_run
//
// One character is taken every cycle while the queue has room; the front
// state update is the loop that sets this.
// The back end hands out one token per cycle while out_pop is held, so an item with
// two tokens stays in it until both are popped; the queue absorbs such bursts.
// A token reaches out_* through the queue head register, then the back-end register.
// rst_n is synchronous; after reset the lexer is idle and both sides empty.
// full rises only when the queue of QUEUE_DEPTH groups has no room.
`include "c_subset_lexer_macros.svh"

module c_subset_lexer #(
  parameter int MAX_TOKEN_LEN = cslx_pkg::MAX_TOKEN_LEN,
  parameter int QUEUE_DEPTH   = cslx_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [7:0]        in_ch,
  input  logic              in_end_of_input,
  output logic              out_empty,
  input  logic              out_pop,
  output logic signed [9:0] out_token_code,
  output logic [7:0]        out_token_length,
  output logic              out_last_of_run
);

  logic               acc;
  logic               q_push, q_pop;
  cslx_pkg::entry_t   q_wr, q_rd;
  cslx_pkg::q_stat_t  q_stat;
  cslx_pkg::f_stat_t  f_stat;

  assign in_full = q_stat.full;
  assign acc     = in_push && !q_stat.full;

  cslx_front #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .acc    (acc),
    .ch     (in_ch),
    .eoi    (in_end_of_input),
    .q_push (q_push),
    .q_wr   (q_wr),
    .f_stat (f_stat)
  );

  cslx_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wr    (q_wr),
    .pop   (q_pop),
    .rd    (q_rd),
    .stat  (q_stat)
  );

  cslx_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_rd             (q_rd),
    .q_stat           (q_stat),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_token_code   (out_token_code),
    .out_token_length (out_token_length),
    .out_last_of_run  (out_last_of_run)
  );

  `CSLX_CHK_NEXT(a_eoi_idle, acc && in_end_of_input, f_stat.mode == cslx_pkg::M_IDLE, "lexer pending after end of input")
  `CSLX_CHK_SAME(a_end_last, !out_empty && out_token_code == cslx_pkg::T_END, out_last_of_run, "end token not last")
  `CSLX_CHK_SAME(a_zero_len, !out_empty && out_token_length == 8'd0, out_token_code == cslx_pkg::T_END, "empty token not end")
  `CSLX_CHK_SAME(a_q_ovf, q_push, !q_stat.full, "push into full queue")

endmodule

/* dv/c_subset_lexer_checker.sv */
// Token checker for the c_subset_lexer: predicts the token stream from accepted
// characters and compares each popped token. Depends on cslx_pkg.
`timescale 1ns / 100ps

module c_subset_lexer_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  logic              in_full,
  input  logic [7:0]        in_ch,
  input  logic              in_end_of_input,
  input  logic              out_empty,
  input  logic              out_pop,
  input  logic signed [9:0] out_token_code,
  input  logic [7:0]        out_token_length,
  input  logic              out_last_of_run,
  output int                errors,
  output int                pending
);

  localparam int LEN_CAP = (cslx_pkg::MAX_TOKEN_LEN < 255) ? cslx_pkg::MAX_TOKEN_LEN : 255;

  cslx_pkg::lexer_mode_t scan_mode = cslx_pkg::M_IDLE;
  int unsigned run_len   = 0;
  logic [47:0] word_head = '0;
  bit          word_long = 0;

  cslx_pkg::token_t tok_q[$];
  cslx_pkg::token_t step_tok[2];
  int               step_n;
  cslx_pkg::token_t want;

  initial begin
    errors  = 0;
    pending = 0;
  end

  task automatic report(input string msg);
    $display("%0t lexer check: %s", $time, msg);
    errors++;
  endtask

  function automatic logic signed [9:0] ascii(input logic [7:0] c);
    return $signed({2'b00, c});
  endfunction

  function automatic bit dec_char(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic bit word_char(input logic [7:0] c);
    return dec_char(c) || ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
           (c == "_");
  endfunction

  function automatic void put_tok(input logic signed [9:0] code, input int unsigned len);
    if (step_n < 2) begin
      step_tok[step_n].code = code;
      step_tok[step_n].len  = (len > LEN_CAP) ? 8'(LEN_CAP) : 8'(len);
      step_tok[step_n].last = 1'b0;
      step_n++;
    end
  endfunction

  function automatic void bump();
    if (run_len < LEN_CAP) run_len++;
  endfunction

  // only the first six characters can match a keyword
  function automatic void grow_word(input logic [7:0] c);
    if (run_len < 6) word_head = {word_head[39:0], c};
    else word_long = 1;
    bump();
  endfunction

  function automatic logic signed [9:0] word_tok();
    if (word_long) return cslx_pkg::T_ID;
    case (word_head)
      {24'd0, "for"}:  return cslx_pkg::T_FOR;
      {"switch"}:      return cslx_pkg::T_SWITCH;
      {16'd0, "case"}: return cslx_pkg::T_CASE;
      {32'd0, "if"}:   return cslx_pkg::T_IF;
      {16'd0, "else"}: return cslx_pkg::T_ELSE;
      {8'd0, "while"}: return cslx_pkg::T_WHILE;
      {24'd0, "int"}, {"double"}, {8'd0, "float"}, {16'd0, "char"}:
        return cslx_pkg::T_TYPE;
      default:         return cslx_pkg::T_ID;
    endcase
  endfunction

  function automatic void open_tok(input logic [7:0] c);
    scan_mode = cslx_pkg::M_IDLE;
    case (c)
      cslx_pkg::CH_SPACE, cslx_pkg::CH_NL: ;
      "(", ")", "{", "}", ";", "#", "[", "]", ":", "\"", "'", "!": put_tok(ascii(c), 1);
      cslx_pkg::CH_PIPE:  scan_mode = cslx_pkg::M_PIPE;
      cslx_pkg::CH_AMP:   scan_mode = cslx_pkg::M_AMP;
      cslx_pkg::CH_LT:    scan_mode = cslx_pkg::M_LT;
      cslx_pkg::CH_GT:    scan_mode = cslx_pkg::M_GT;
      cslx_pkg::CH_EQ:    scan_mode = cslx_pkg::M_EQ;
      cslx_pkg::CH_PLUS:  scan_mode = cslx_pkg::M_PLUS;
      cslx_pkg::CH_MINUS: scan_mode = cslx_pkg::M_MINUS;
      cslx_pkg::CH_STAR:  scan_mode = cslx_pkg::M_STAR;
      cslx_pkg::CH_SLASH: scan_mode = cslx_pkg::M_SLASH;
      default: begin
        if (dec_char(c)) begin
          scan_mode = cslx_pkg::M_NUM;
          run_len   = 1;
        end else if (word_char(c)) begin
          scan_mode = cslx_pkg::M_WORD;
          run_len   = 0;
          word_head = '0;
          word_long = 0;
          grow_word(c);
        end else begin
          put_tok(cslx_pkg::T_BAD, 1);
        end
      end
    endcase
  endfunction

  function automatic void close_tok();
    case (scan_mode)
      cslx_pkg::M_PIPE:  put_tok(ascii(cslx_pkg::CH_PIPE), 1);
      cslx_pkg::M_AMP:   put_tok(ascii(cslx_pkg::CH_AMP), 1);
      cslx_pkg::M_LT:    put_tok(ascii(cslx_pkg::CH_LT), 1);
      cslx_pkg::M_GT:    put_tok(ascii(cslx_pkg::CH_GT), 1);
      cslx_pkg::M_EQ:    put_tok(ascii(cslx_pkg::CH_EQ), 1);
      cslx_pkg::M_PLUS:  put_tok(ascii(cslx_pkg::CH_PLUS), 1);
      cslx_pkg::M_MINUS: put_tok(ascii(cslx_pkg::CH_MINUS), 1);
      cslx_pkg::M_STAR:  put_tok(ascii(cslx_pkg::CH_STAR), 1);
      cslx_pkg::M_SLASH: put_tok(ascii(cslx_pkg::CH_SLASH), 1);
      cslx_pkg::M_NUM:   put_tok(cslx_pkg::T_INT, run_len);
      cslx_pkg::M_WORD:  put_tok(word_tok(), run_len);
      default: ;
    endcase
    scan_mode = cslx_pkg::M_IDLE;
  endfunction

  // true when c continues the pending token
  function automatic bit absorb(input logic [7:0] c);
    logic signed [9:0] code;
    code = '0;
    case (scan_mode)
      cslx_pkg::M_PIPE: if (c == cslx_pkg::CH_PIPE) code = cslx_pkg::T_OR;
      cslx_pkg::M_AMP:  if (c == cslx_pkg::CH_AMP) code = cslx_pkg::T_AND;
      cslx_pkg::M_LT:   if (c == cslx_pkg::CH_EQ) code = cslx_pkg::T_LE;
      cslx_pkg::M_GT:   if (c == cslx_pkg::CH_EQ) code = cslx_pkg::T_GE;
      cslx_pkg::M_EQ:   if (c == cslx_pkg::CH_EQ) code = cslx_pkg::T_EQ;
      cslx_pkg::M_PLUS: begin
        if (c == cslx_pkg::CH_EQ) code = ascii(cslx_pkg::CH_EQ);
        else if (c == cslx_pkg::CH_PLUS) code = cslx_pkg::T_INC;
      end
      cslx_pkg::M_MINUS: begin
        if (c == cslx_pkg::CH_EQ) begin
          code = ascii(cslx_pkg::CH_EQ);
        end else if (c == cslx_pkg::CH_MINUS) begin
          code = cslx_pkg::T_DEC;
        end else if (dec_char(c)) begin
          scan_mode = cslx_pkg::M_NUM;
          run_len   = 2;
          return 1;
        end
      end
      cslx_pkg::M_STAR, cslx_pkg::M_SLASH: if (c == cslx_pkg::CH_EQ) code = ascii(cslx_pkg::CH_EQ);
      cslx_pkg::M_NUM: begin
        if (dec_char(c)) begin
          bump();
          return 1;
        end
        return 0;
      end
      cslx_pkg::M_WORD: begin
        if (word_char(c)) begin
          grow_word(c);
          return 1;
        end
        return 0;
      end
      default: return 0;
    endcase
    if (code == 0) return 0;
    put_tok(code, 2);
    scan_mode = cslx_pkg::M_IDLE;
    return 1;
  endfunction

  function automatic void lex_char(input logic [7:0] c, input logic eoi);
    step_n = 0;
    if (eoi) begin
      close_tok();
      put_tok(cslx_pkg::T_END, 0);
    end else if (scan_mode == cslx_pkg::M_IDLE) begin
      open_tok(c);
    end else if (!absorb(c)) begin
      close_tok();
      open_tok(c);
    end
    if (step_n > 0) step_tok[step_n - 1].last = 1'b1;
    for (int i = 0; i < step_n; i++) tok_q.push_back(step_tok[i]);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      scan_mode = cslx_pkg::M_IDLE;
      run_len   = 0;
      word_head = '0;
      word_long = 0;
      tok_q.delete();
    end else begin
      if (in_push && !in_full) lex_char(in_ch, in_end_of_input);
      if (out_pop && !out_empty) begin
        if (tok_q.size() == 0) begin
          report($sformatf("unexpected token code %0d len %0d last %0b",
                           out_token_code, out_token_length, out_last_of_run));
        end else begin
          want = tok_q.pop_front();
          if (out_token_code !== want.code || out_token_length !== want.len ||
              out_last_of_run !== want.last) begin
            report($sformatf("token code %0d len %0d last %0b, expected %0d %0d %0b",
                             out_token_code, out_token_length, out_last_of_run,
                             want.code, want.len, want.last));
          end
        end
      end
    end
    pending = tok_q.size();
  end

endmodule

/* dv/c_subset_lexer_tb.sv */
// Testbench top for the c_subset_lexer: drives characters and pops tokens with
// random stalls; c_subset_lexer_checker does the checking. Depends on cslx_pkg.
`timescale 1ns / 100ps

module c_subset_lexer_tb;

  logic              clk;
  logic              rst_n           = 0;
  logic              in_push         = 0;
  logic [7:0]        in_ch           = '0;
  logic              in_end_of_input = 0;
  logic              out_pop         = 0;
  logic              in_full;
  logic              out_empty;
  logic signed [9:0] out_token_code;
  logic [7:0]        out_token_length;
  logic              out_last_of_run;

  int err_cnt;
  int tok_pending;
  int chars_sent = 0;
  bit src_idle   = 1;
  bit snk_idle   = 1;

  c_subset_lexer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_ch            (in_ch),
    .in_end_of_input  (in_end_of_input),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_token_code   (out_token_code),
    .out_token_length (out_token_length),
    .out_last_of_run  (out_last_of_run)
  );

  c_subset_lexer_checker tok_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_ch            (in_ch),
    .in_end_of_input  (in_end_of_input),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_token_code   (out_token_code),
    .out_token_length (out_token_length),
    .out_last_of_run  (out_last_of_run),
    .errors           (err_cnt),
    .pending          (tok_pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("c_subset_lexer: mismatch");
    $finish;
  end

  // token sink
  initial begin
    forever begin
      @(posedge clk);
      if (snk_idle && $urandom_range(0, 7) == 0) begin
        out_pop <= 0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_pop <= 1;
    end
  end

  task automatic push_char(input logic [7:0] c, input logic eoi);
    if (src_idle && $urandom_range(0, 9) == 0) begin
      in_push <= 0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_push         <= 1;
    in_ch           <= c;
    in_end_of_input <= eoi;
    @(posedge clk);
    while (in_full) @(posedge clk);
    chars_sent++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], 0);
  endtask

  function automatic logic [7:0] pick_alnum(input bit lead);
    int k;
    k = $urandom_range(lead ? 10 : 0, 62);
    if (k < 10) return 8'("0" + k);
    else if (k < 36) return 8'("a" + k - 10);
    else if (k < 62) return 8'("A" + k - 36);
    return "_";
  endfunction

  // keywords and near misses
  function automatic string pick_word(input int k);
    case (k)
      0:  return "for";
      1:  return "switch";
      2:  return "case";
      3:  return "if";
      4:  return "else";
      5:  return "while";
      6:  return "int";
      7:  return "double";
      8:  return "float";
      9:  return "char";
      10: return "fo";
      11: return "iff";
      12: return "whilex";
      default: return "doubles";
    endcase
  endfunction

  function automatic string pick_op(input int k);
    case (k)
      0:  return "|";
      1:  return "||";
      2:  return "&";
      3:  return "&&";
      4:  return "<";
      5:  return "<=";
      6:  return ">";
      7:  return ">=";
      8:  return "=";
      9:  return "==";
      10: return "+";
      11: return "++";
      12: return "+=";
      13: return "-";
      14: return "--";
      15: return "-=";
      16: return "*";
      17: return "*=";
      18: return "/";
      default: return "/=";
    endcase
  endfunction

  task automatic push_piece();
    int    k;
    int    n;
    string punct;
    punct = "(){};#[]:\"'!";
    k = $urandom_range(0, 99);
    if (k < 15) begin
      push_text(pick_word($urandom_range(0, 13)));
    end else if (k < 30) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
      push_char(pick_alnum(1), 0);
      repeat (n - 1) push_char(pick_alnum(0), 0);
    end else if (k < 42) begin
      if ($urandom_range(0, 2) == 0) push_char(cslx_pkg::CH_MINUS, 0);
      repeat ($urandom_range(1, 6)) push_char(8'("0" + $urandom_range(0, 9)), 0);
    end else if (k < 62) begin
      push_text(pick_op($urandom_range(0, 19)));
    end else if (k < 70) begin
      push_char(punct[$urandom_range(0, 11)], 0);
    end else if (k < 78) begin
      push_char(8'($urandom_range(0, 255)), 0);
    end else if (k < 80) begin
      push_char(8'($urandom_range(0, 255)), 1);
    end else begin
      push_char($urandom_range(0, 1) ? cslx_pkg::CH_SPACE : cslx_pkg::CH_NL, 0);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // lone and doubled operators, minus number, number then letter, odd bytes
    push_text("x||y&z&&-7<=9a>=!\t");
    push_char(8'hff, 0);
    push_char(8'h00, 0);
    push_char(8'hff, 1);
    push_char(8'h00, 1);

    // saturating lengths
    push_char(pick_alnum(1), 0);
    repeat (259) push_char(pick_alnum(0), 0);
    push_char(cslx_pkg::CH_SPACE, 0);
    push_char(cslx_pkg::CH_MINUS, 0);
    repeat (258) push_char(8'("0" + $urandom_range(0, 9)), 0);

    while (chars_sent < 1200) begin
      if (chars_sent > 1000) begin
        src_idle = 0;
        snk_idle = 0;
      end
      push_piece();
    end
    push_char(8'($urandom_range(0, 255)), 1);
    in_push <= 0;
    @(posedge clk);

    wait (tok_pending == 0);
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("c_subset_lexer: match");
    end else begin
      $display("c_subset_lexer: mismatch");
    end
    $finish;
  end

endmodule

/* c_subset_lexer.f */
+incdir+design
design/cslx_pkg.sv
design/cslx_front.sv
design/cslx_queue.sv
design/cslx_back.sv
design/c_subset_lexer.sv
dv/c_subset_lexer_checker.sv
dv/c_subset_lexer_tb.sv
